// ===== rtl/core/bpc_pkg.sv =====
// Shared types and codes for the button press classifier core.
// Holds phase, event, indication and register codes and the lane result types.
// Depends on nothing; every module of the core imports it.
package bpc_pkg;

  localparam int NUM_SLOTS = 3;
  localparam int THR_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [2:0] PH_WAITING     = 3'd0;
  localparam logic [2:0] PH_PREAMBLE    = 3'd1;
  localparam logic [2:0] PH_SHORT       = 3'd2;
  localparam logic [2:0] PH_LONG_ARMED  = 3'd3;
  localparam logic [2:0] PH_LONG        = 3'd4;
  localparam logic [2:0] PH_DOUBLE_LONG = 3'd5;
  localparam logic [2:0] PH_END         = 3'd6;

  localparam logic [1:0] EV_NONE        = 2'd0;
  localparam logic [1:0] EV_SHORT       = 2'd1;
  localparam logic [1:0] EV_LONG        = 2'd2;
  localparam logic [1:0] EV_DOUBLE_LONG = 2'd3;

  localparam logic [1:0] LED_NONE       = 2'd0;
  localparam logic [1:0] LED_BLINK      = 2'd1;
  localparam logic [1:0] LED_LONG_BLINK = 2'd2;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RELEASE     = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG        = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DOUBLE_LONG = 2'd3;

  localparam logic [THR_WIDTH-1:0] DEBOUNCE_RESET    = 16'd5;
  localparam logic [THR_WIDTH-1:0] RELEASE_RESET     = 16'd20;
  localparam logic [THR_WIDTH-1:0] LONG_RESET        = 16'd200;
  localparam logic [THR_WIDTH-1:0] DOUBLE_LONG_RESET = 16'd300;

  typedef struct packed {
    logic [THR_WIDTH-1:0] debounce_ticks;
    logic [THR_WIDTH-1:0] release_ticks;
    logic [THR_WIDTH-1:0] long_ticks;
    logic [THR_WIDTH-1:0] double_long_ticks;
  } thresholds_t;

  typedef struct packed {
    logic [1:0] press_event;
    logic [1:0] led_request;
  } lane_res_t;

  typedef lane_res_t [NUM_SLOTS-1:0] tick_res_t;

endpackage

// ===== rtl/core/bpc_lane.sv =====
// One button lane: the press phase machine with its hold and release counters.
// Produces this tick's event and indication for its button.
// Depends on bpc_pkg.
module bpc_lane #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                pressed,
  input  bpc_pkg::thresholds_t thr,
  output bpc_pkg::lane_res_t  res
);
  import bpc_pkg::*;

  localparam int CMP_WIDTH = (COUNT_WIDTH > THR_WIDTH) ? COUNT_WIDTH : THR_WIDTH;

  logic [2:0]             phase;
  logic [2:0]             phase_next;
  logic [COUNT_WIDTH-1:0] hold_count;
  logic [COUNT_WIDTH-1:0] hold_count_next;
  logic [COUNT_WIDTH-1:0] release_count;
  logic [COUNT_WIDTH-1:0] release_count_next;
  logic [COUNT_WIDTH-1:0] hold_inc;
  logic [COUNT_WIDTH-1:0] release_inc;
  logic [THR_WIDTH-1:0]   hold_thr;
  logic                   hold_hit;
  logic                   release_hit;

  assign hold_inc    = (&hold_count) ? hold_count : hold_count + COUNT_WIDTH'(1);
  assign release_inc = (&release_count) ? release_count : release_count + COUNT_WIDTH'(1);

  always_comb begin
    case (phase)
      PH_PREAMBLE:   hold_thr = thr.long_ticks;
      PH_LONG_ARMED: hold_thr = thr.double_long_ticks;
      default:       hold_thr = thr.debounce_ticks;
    endcase
  end

  assign hold_hit    = CMP_WIDTH'(hold_inc) >= CMP_WIDTH'(hold_thr);
  assign release_hit = CMP_WIDTH'(release_inc) >= CMP_WIDTH'(thr.release_ticks);

  always_comb begin
    phase_next         = phase;
    hold_count_next    = hold_count;
    release_count_next = release_count;
    res.press_event    = EV_NONE;
    res.led_request    = LED_NONE;
    case (phase)
      PH_WAITING: begin
        if (pressed) begin
          hold_count_next = hold_inc;
          if (hold_hit) begin
            phase_next      = PH_PREAMBLE;
            hold_count_next = '0;
          end
        end
      end
      PH_PREAMBLE: begin
        if (pressed) begin
          hold_count_next = hold_inc;
          if (hold_hit) begin
            res.led_request    = LED_BLINK;
            phase_next         = PH_LONG_ARMED;
            hold_count_next    = '0;
            release_count_next = '0;
          end
        end else begin
          release_count_next = release_inc;
          if (release_hit) begin
            res.led_request    = LED_BLINK;
            phase_next         = PH_SHORT;
            release_count_next = '0;
          end
        end
      end
      PH_SHORT: begin
        res.press_event = EV_SHORT;
        phase_next      = PH_END;
      end
      PH_LONG_ARMED: begin
        if (pressed) begin
          hold_count_next = hold_inc;
          if (hold_hit) begin
            res.led_request = LED_LONG_BLINK;
            phase_next      = PH_DOUBLE_LONG;
            hold_count_next = '0;
          end
        end else begin
          release_count_next = release_inc;
          if (release_hit) begin
            phase_next         = PH_LONG;
            release_count_next = '0;
          end
        end
      end
      PH_LONG: begin
        res.press_event = EV_LONG;
        phase_next      = PH_END;
      end
      PH_DOUBLE_LONG: begin
        res.press_event = EV_DOUBLE_LONG;
        phase_next      = PH_END;
      end
      PH_END: begin
        if (!pressed) begin
          phase_next = PH_WAITING;
        end
      end
      default: begin
        phase_next = PH_WAITING;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WAITING;
      hold_count    <= '0;
      release_count <= '0;
    end else if (step) begin
      phase         <= phase_next;
      hold_count    <= hold_count_next;
      release_count <= release_count_next;
    end
  end

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase) && $stable(hold_count) && $stable(release_count))
    else $error("lane state changed without a transfer");

  a_event_then_end: assert property (@(posedge clk) disable iff (rst)
    step && (phase == PH_SHORT || phase == PH_LONG || phase == PH_DOUBLE_LONG)
    |=> phase == PH_END)
    else $error("lane did not move to end after an event");

  a_end_release: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_END && !pressed |=> phase == PH_WAITING)
    else $error("lane did not return to waiting on release");

endmodule

// ===== rtl/core/bpc_merge.sv =====
// Merging stage: gathers the lane results of one tick into the output register.
// A skid register catches one input transfer while the output is stalled.
// Depends on bpc_pkg.
module bpc_merge (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bpc_pkg::tick_res_t lanes,
  output logic               out_valid,
  input  logic               out_ready,
  output bpc_pkg::tick_res_t out_res
);
  import bpc_pkg::*;

  logic      skid_valid;
  tick_res_t skid_res;
  logic      in_xfer;

  assign in_ready = !skid_valid;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (in_xfer) begin
        out_res <= lanes;
      end
    end else if (in_xfer) begin
      skid_res <= lanes;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && in_xfer |=> skid_valid)
    else $error("transfer during output stall was not caught by the skid register");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_ready |=> out_valid && !skid_valid)
    else $error("skid register did not drain into the output register");

endmodule

// ===== rtl/core/button_press_classifier_core.sv =====
// Each tick's lane results are registered in the output register, or in the skid register while the output stalls.
// Throughput: one tick per cycle while the skid register is empty; each button lane updates its phase and counters
// on each accepted tick, and a skid register takes one further transfer when the output stalls.
// Reset: thresholds return to 5, 20, 200 and 300 ticks, every lane to waiting with
// cleared counters, and the output and skid registers empty.
// Depends on bpc_pkg, bpc_lane and bpc_merge.
module button_press_classifier_core #(
  parameter int BUTTONS     = 3,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [bpc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [bpc_pkg::THR_WIDTH-1:0]         cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  button_a_pressed,
  input  logic                                  button_b_pressed,
  input  logic                                  button_c_pressed,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            press_event_a,
  output logic [1:0]                            press_event_b,
  output logic [1:0]                            press_event_c,
  output logic [1:0]                            led_request_a,
  output logic [1:0]                            led_request_b,
  output logic [1:0]                            led_request_c
);
  import bpc_pkg::*;

  thresholds_t           thr;
  logic [NUM_SLOTS-1:0]  pressed;
  tick_res_t             lanes;
  tick_res_t             out_res;
  logic                  step;

  assign pressed = {button_c_pressed, button_b_pressed, button_a_pressed};
  assign step    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.debounce_ticks    <= DEBOUNCE_RESET;
      thr.release_ticks     <= RELEASE_RESET;
      thr.long_ticks        <= LONG_RESET;
      thr.double_long_ticks <= DOUBLE_LONG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:    thr.debounce_ticks    <= cfg_data;
        REG_RELEASE:     thr.release_ticks     <= cfg_data;
        REG_LONG:        thr.long_ticks        <= cfg_data;
        REG_DOUBLE_LONG: thr.double_long_ticks <= cfg_data;
        default:         thr                   <= thr;
      endcase
    end
  end

  for (genvar b = 0; b < NUM_SLOTS; b++) begin : g_lane
    if (b < BUTTONS) begin : g_used
      bpc_lane #(
        .COUNT_WIDTH(COUNT_WIDTH)
      ) u_lane (
        .clk     (clk),
        .rst     (rst),
        .step    (step),
        .pressed (pressed[b]),
        .thr     (thr),
        .res     (lanes[b])
      );
    end else begin : g_unused
      assign lanes[b] = '0;
    end
  end

  bpc_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .lanes     (lanes),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign press_event_a = out_res[0].press_event;
  assign press_event_b = out_res[1].press_event;
  assign press_event_c = out_res[2].press_event;
  assign led_request_a = out_res[0].led_request;
  assign led_request_b = out_res[1].led_request;
  assign led_request_c = out_res[2].led_request;

endmodule

// ===== tb/tb_button_press_classifier_core.sv =====
// Self-checking testbench for button_press_classifier_core: a directed table, then random
// press sequences under several threshold settings, each result checked against the table or a predictor.
// Depends on bpc_pkg and the core RTL only.
module tb_button_press_classifier_core;
  import bpc_pkg::*;

  localparam int QUIET_LIMIT = 400;
  localparam int DIR_ROWS = 16;

  typedef struct packed {
    logic       press_a;
    logic       press_b;
    logic       press_c;
    logic       known;
    logic [1:0] ev_a;
    logic [1:0] ev_b;
    logic [1:0] ev_c;
    logic [1:0] led_a;
    logic [1:0] led_b;
    logic [1:0] led_c;
  } dir_row_t;

  // Walked with thresholds 1, 1, 2 and 1: button a gives a short press, b a long press and
  // c a double-long press; the later rows are left to the predictor.
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    {1'b1, 1'b1, 1'b1, 1'b1, EV_NONE, EV_NONE, EV_NONE, LED_NONE, LED_NONE, LED_NONE},
    {1'b0, 1'b1, 1'b1, 1'b1, EV_NONE, EV_NONE, EV_NONE, LED_BLINK, LED_NONE, LED_NONE},
    {1'b0, 1'b1, 1'b1, 1'b1, EV_SHORT, EV_NONE, EV_NONE, LED_NONE, LED_BLINK, LED_BLINK},
    {1'b0, 1'b0, 1'b1, 1'b1, EV_NONE, EV_NONE, EV_NONE, LED_NONE, LED_NONE, LED_LONG_BLINK},
    {1'b0, 1'b0, 1'b1, 1'b1, EV_NONE, EV_LONG, EV_DOUBLE_LONG, LED_NONE, LED_NONE, LED_NONE},
    {1'b0, 1'b0, 1'b1, 1'b1, EV_NONE, EV_NONE, EV_NONE, LED_NONE, LED_NONE, LED_NONE},
    {1'b0, 1'b0, 1'b0, 1'b1, EV_NONE, EV_NONE, EV_NONE, LED_NONE, LED_NONE, LED_NONE},
    {1'b1, 1'b0, 1'b0, 1'b0, EV_NONE, EV_NONE, EV_NONE, LED_NONE, LED_NONE, LED_NONE},
    {1'b1, 1'b1, 1'b0, 1'b0, EV_NONE, EV_NONE, EV_NONE, LED_NONE, LED_NONE, LED_NONE},
    {1'b1, 1'b1, 1'b1, 1'b0, EV_NONE, EV_NONE, EV_NONE, LED_NONE, LED_NONE, LED_NONE},
    {1'b0, 1'b0, 1'b0, 1'b0, EV_NONE, EV_NONE, EV_NONE, LED_NONE, LED_NONE, LED_NONE},
    {1'b1, 1'b0, 1'b1, 1'b0, EV_NONE, EV_NONE, EV_NONE, LED_NONE, LED_NONE, LED_NONE},
    {1'b0, 1'b1, 1'b0, 1'b0, EV_NONE, EV_NONE, EV_NONE, LED_NONE, LED_NONE, LED_NONE},
    {1'b1, 1'b1, 1'b1, 1'b0, EV_NONE, EV_NONE, EV_NONE, LED_NONE, LED_NONE, LED_NONE},
    {1'b1, 1'b1, 1'b1, 1'b0, EV_NONE, EV_NONE, EV_NONE, LED_NONE, LED_NONE, LED_NONE},
    {1'b0, 1'b0, 1'b0, 1'b0, EV_NONE, EV_NONE, EV_NONE, LED_NONE, LED_NONE, LED_NONE}
  };

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [THR_WIDTH-1:0]       cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic                       button_a_pressed;
  logic                       button_b_pressed;
  logic                       button_c_pressed;
  logic                       out_valid;
  logic                       out_ready;
  logic [1:0]                 press_event_a;
  logic [1:0]                 press_event_b;
  logic [1:0]                 press_event_c;
  logic [1:0]                 led_request_a;
  logic [1:0]                 led_request_b;
  logic [1:0]                 led_request_c;

  logic [THR_WIDTH-1:0] thr_deb;
  logic [THR_WIDTH-1:0] thr_rel;
  logic [THR_WIDTH-1:0] thr_long;
  logic [THR_WIDTH-1:0] thr_dbl;
  logic [2:0]           lane_phase [NUM_SLOTS];
  logic [15:0]          lane_hold [NUM_SLOTS];
  logic [15:0]          lane_release [NUM_SLOTS];

  tick_res_t expected_q [$];
  int        run_left [NUM_SLOTS];
  logic      run_level [NUM_SLOTS];
  bit        idle_on;
  int        mismatches;
  int        ticks_sent;
  int        results_seen;
  int        short_seen;
  int        long_seen;
  int        double_seen;
  int        quiet_cycles = 0;

  button_press_classifier_core dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .button_a_pressed (button_a_pressed),
    .button_b_pressed (button_b_pressed),
    .button_c_pressed (button_c_pressed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .press_event_a    (press_event_a),
    .press_event_b    (press_event_b),
    .press_event_c    (press_event_c),
    .led_request_a    (led_request_a),
    .led_request_b    (led_request_b),
    .led_request_c    (led_request_c)
  );

  always #2 clk = ~clk;

  function automatic logic [15:0] sat_inc(input logic [15:0] count);
    return (count == '1) ? count : count + 16'd1;
  endfunction

  function automatic tick_res_t classify_tick(input logic [2:0] levels);
    tick_res_t res;
    res = '0;
    for (int b = 0; b < NUM_SLOTS; b++) begin
      case (lane_phase[b])
        PH_WAITING: begin
          if (levels[b]) begin
            lane_hold[b] = sat_inc(lane_hold[b]);
            if (lane_hold[b] >= thr_deb) begin
              lane_phase[b] = PH_PREAMBLE;
              lane_hold[b] = '0;
            end
          end
        end
        PH_PREAMBLE: begin
          if (levels[b]) begin
            lane_hold[b] = sat_inc(lane_hold[b]);
            if (lane_hold[b] >= thr_long) begin
              res[b].led_request = LED_BLINK;
              lane_phase[b] = PH_LONG_ARMED;
              lane_hold[b] = '0;
              lane_release[b] = '0;
            end
          end else begin
            lane_release[b] = sat_inc(lane_release[b]);
            if (lane_release[b] >= thr_rel) begin
              res[b].led_request = LED_BLINK;
              lane_phase[b] = PH_SHORT;
              lane_release[b] = '0;
            end
          end
        end
        PH_SHORT: begin
          res[b].press_event = EV_SHORT;
          lane_phase[b] = PH_END;
        end
        PH_LONG_ARMED: begin
          if (levels[b]) begin
            lane_hold[b] = sat_inc(lane_hold[b]);
            if (lane_hold[b] >= thr_dbl) begin
              res[b].led_request = LED_LONG_BLINK;
              lane_phase[b] = PH_DOUBLE_LONG;
              lane_hold[b] = '0;
            end
          end else begin
            lane_release[b] = sat_inc(lane_release[b]);
            if (lane_release[b] >= thr_rel) begin
              lane_phase[b] = PH_LONG;
              lane_release[b] = '0;
            end
          end
        end
        PH_LONG: begin
          res[b].press_event = EV_LONG;
          lane_phase[b] = PH_END;
        end
        PH_DOUBLE_LONG: begin
          res[b].press_event = EV_DOUBLE_LONG;
          lane_phase[b] = PH_END;
        end
        PH_END: begin
          if (!levels[b]) lane_phase[b] = PH_WAITING;
        end
        default: lane_phase[b] = PH_WAITING;
      endcase
    end
    return res;
  endfunction

  // Run lengths are drawn around the thresholds so that every phase is reached, with some
  // glitches and broken releases mixed in.
  function automatic int run_length(input logic pressed);
    int d;
    int r;
    int l;
    int dl;
    int sel;
    d = (thr_deb == 0) ? 1 : int'(thr_deb);
    r = (thr_rel == 0) ? 1 : int'(thr_rel);
    l = (thr_long == 0) ? 1 : int'(thr_long);
    dl = (thr_dbl == 0) ? 1 : int'(thr_dbl);
    sel = $urandom_range(0, 9);
    if (pressed) begin
      if (sel < 2) return $urandom_range(1, 2);
      if (sel < 5) return d + $urandom_range(0, l - 1);
      if (sel < 7) return d + l + $urandom_range(0, dl - 1);
      if (sel < 9) return d + l + dl + $urandom_range(0, 3);
      return $urandom_range(1, 2 * (d + l + dl) + 1);
    end
    if (sel < 3) return $urandom_range(1, (r > 1) ? r - 1 : 1);
    return r + $urandom_range(0, 3);
  endfunction

  function automatic logic [2:0] next_levels();
    logic [2:0] levels;
    for (int b = 0; b < NUM_SLOTS; b++) begin
      if (run_left[b] == 0) begin
        run_level[b] = ~run_level[b];
        run_left[b] = run_length(run_level[b]);
      end
      run_left[b]--;
      levels[b] = run_level[b] ^ ($urandom_range(0, 19) == 0);
    end
    return levels;
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_DEBOUNCE:    thr_deb = value;
      REG_RELEASE:     thr_rel = value;
      REG_LONG:        thr_long = value;
      REG_DOUBLE_LONG: thr_dbl = value;
      default: ;
    endcase
  endtask

  task automatic program_thresholds(input logic [15:0] deb, input logic [15:0] rel,
                                    input logic [15:0] lng, input logic [15:0] dbl);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_RELEASE, rel);
    write_reg(REG_LONG, lng);
    write_reg(REG_DOUBLE_LONG, dbl);
    cfg_we <= 1'b0;
  endtask

  task automatic deliver(input logic [2:0] levels, input logic known, input tick_res_t typed);
    tick_res_t pred;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    button_a_pressed <= levels[0];
    button_b_pressed <= levels[1];
    button_c_pressed <= levels[2];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = classify_tick(levels);
    ticks_sent++;
    expected_q.push_back(known ? typed : pred);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] deb, input logic [15:0] rel,
                           input logic [15:0] lng, input logic [15:0] dbl, input int count);
    logic [2:0] levels;
    drain();
    program_thresholds(deb, rel, lng, dbl);
    for (int b = 0; b < NUM_SLOTS; b++) run_left[b] = 0;
    repeat (count) begin
      levels = next_levels();
      deliver(levels, 1'b0, '0);
    end
  endtask

  task automatic note_mismatch(input string field, input int lane, input int want,
                               input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("Mismatch on %s of button %0d: expected %0d, got %0d", field, lane, want, got);
  endtask

  task automatic check_result(input tick_res_t got);
    tick_res_t want;
    results_seen++;
    for (int b = 0; b < NUM_SLOTS; b++) begin
      if (got[b].press_event == EV_SHORT) short_seen++;
      if (got[b].press_event == EV_LONG) long_seen++;
      if (got[b].press_event == EV_DOUBLE_LONG) double_seen++;
    end
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Output transfer with no result expected: %h", got);
      return;
    end
    want = expected_q.pop_front();
    for (int b = 0; b < NUM_SLOTS; b++) begin
      if (got[b].press_event !== want[b].press_event)
        note_mismatch("press_event", b, want[b].press_event, got[b].press_event);
      if (got[b].led_request !== want[b].led_request)
        note_mismatch("led_request", b, want[b].led_request, got[b].led_request);
    end
  endtask

  initial begin
    int stall_left;
    tick_res_t got;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got[0].press_event = press_event_a;
        got[1].press_event = press_event_b;
        got[2].press_event = press_event_c;
        got[0].led_request = led_request_a;
        got[1].led_request = led_request_b;
        got[2].led_request = led_request_c;
        check_result(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= (stall_left == 0);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 11);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    dir_row_t  row;
    tick_res_t typed;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_DEBOUNCE;
    cfg_data <= '0;
    in_valid <= 1'b0;
    button_a_pressed <= 1'b0;
    button_b_pressed <= 1'b0;
    button_c_pressed <= 1'b0;
    mismatches = 0;
    ticks_sent = 0;
    results_seen = 0;
    short_seen = 0;
    long_seen = 0;
    double_seen = 0;
    idle_on = 1'b1;
    thr_deb = DEBOUNCE_RESET;
    thr_rel = RELEASE_RESET;
    thr_long = LONG_RESET;
    thr_dbl = DOUBLE_LONG_RESET;
    for (int b = 0; b < NUM_SLOTS; b++) begin
      lane_phase[b] = PH_WAITING;
      lane_hold[b] = '0;
      lane_release[b] = '0;
      run_left[b] = 0;
      run_level[b] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    program_thresholds(16'd1, 16'd1, 16'd2, 16'd1);
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIRECTED[i];
      typed[0].press_event = row.ev_a;
      typed[1].press_event = row.ev_b;
      typed[2].press_event = row.ev_c;
      typed[0].led_request = row.led_a;
      typed[1].led_request = row.led_b;
      typed[2].led_request = row.led_c;
      deliver({row.press_c, row.press_b, row.press_a}, row.known, typed);
    end

    run_phase(16'd3, 16'd4, 16'd6, 16'd5, 300);
    run_phase(16'd1, 16'd1, 16'd1, 16'd1, 250);
    run_phase(16'd0, 16'd0, 16'd0, 16'd0, 150);
    run_phase(16'd2, 16'd6, 16'd10, 16'd8, 300);
    run_phase(DEBOUNCE_RESET, RELEASE_RESET, LONG_RESET, DOUBLE_LONG_RESET, 340);

    // Thresholds at their maximum: a steady hold reaches no threshold, so it raises no new event.
    drain();
    idle_on = 1'b0;
    program_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (100) deliver(3'b111, 1'b0, '0);
    repeat (12) deliver(3'b000, 1'b0, '0);

    run_phase(16'd4, 16'd3, 16'd7, 16'd6, 200);

    drain();
    repeat (4) @(posedge clk);
    $display("Ran %0d ticks under directed, random, zero and full-scale threshold settings.",
             ticks_sent);
    $display("Checked %0d results with %0d short, %0d long and %0d double-long events.",
             results_seen, short_seen, long_seen, double_seen);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, expected_q.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
